// File: rtl/core/rbs_pkg.sv
package rbs_pkg;

   // fixed field widths
   localparam int COORD_W = 32;
   localparam int EPS_W   = 31;
   localparam int CSR_IDX_W = 2;
   localparam int AXES    = 3;

   // quotient bits resolved by the divider, one per stage
   localparam int QUOT_W  = 32;
   // divider depth: operand prep stage plus one stage per quotient bit
   localparam int DIV_LAT = QUOT_W + 1;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_EPSILON = 2'd0,
      CSR_T_START = 2'd1,
      CSR_T_END   = 2'd2
   } csr_index_type;

   localparam logic [EPS_W-1:0]   EPSILON_RST = 31'd66;
   localparam logic [COORD_W-1:0] T_START_RST = 32'h0000_0000;
   localparam logic [COORD_W-1:0] T_END_RST   = 32'h7FFF_FFFF;

   localparam logic signed [COORD_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [COORD_W-1:0] Q_MIN = 32'sh8000_0000;

   // per item flags that ride beside the dividers
   typedef struct packed {
      logic             valid;
      logic             slab_miss;
      logic [AXES-1:0]  parallel;
   } side_type;

endpackage

// File: rtl/core/rbs_if.sv
// ray and box item channel
interface rbs_req_if;
   logic valid;
   logic ready;
   logic signed [31:0] origin_x;
   logic signed [31:0] origin_y;
   logic signed [31:0] origin_z;
   logic signed [31:0] dir_x;
   logic signed [31:0] dir_y;
   logic signed [31:0] dir_z;
   logic signed [31:0] box_min_x;
   logic signed [31:0] box_min_y;
   logic signed [31:0] box_min_z;
   logic signed [31:0] box_max_x;
   logic signed [31:0] box_max_y;
   logic signed [31:0] box_max_z;

   modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                   box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
                   input ready);
   modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                 box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
                 output ready);
endinterface

// result item channel
interface rbs_rsp_if;
   logic valid;
   logic ready;
   logic hit;
   logic signed [31:0] t_near_out;
   logic signed [31:0] t_far_out;

   modport source (output valid, hit, t_near_out, t_far_out, input ready);
   modport sink (input valid, hit, t_near_out, t_far_out, output ready);
endinterface

// register write channel
interface rbs_csr_if;
   logic valid;
   logic ready;
   logic [rbs_pkg::CSR_IDX_W-1:0] index;
   logic [31:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/core/ray_box_slab_test.sv
// channel | dir | handshake   | item
// req_ch  | in  | valid/ready | ray origin, direction, box min and max corners
// rsp_ch  | out | valid/ready | hit, t_near_out, t_far_out
// csr_ch  | in  | valid/ready | register index and data, always ready
//
// one item per cycle while rsp is not stalled; items pass through capture, prep,
// the 32 one-bit stages of the six dividers, sort, fold and output registers.
// reset clears all valid bits and loads epsilon, t_start and t_end defaults.
// a stall on rsp freezes the whole pipeline; req ready drops in the same cycle.
module ray_box_slab_test #(
   parameter int FRAC_BITS = 16
) (
   input logic           clock,
   input logic           reset,
   rbs_req_if.sink       req_ch,
   rbs_rsp_if.source     rsp_ch,
   rbs_csr_if.sink       csr_ch
);

   localparam int Axes = rbs_pkg::AXES;
   localparam int Lat  = rbs_pkg::DIV_LAT;

   logic advance;

   logic [rbs_pkg::EPS_W-1:0]   epsilon_ff;
   logic signed [31:0]          t_start_ff;
   logic signed [31:0]          t_end_ff;

   // stage a: captured item
   logic                        a_valid_ff;
   logic signed [31:0]          a_org_ff  [Axes];
   logic signed [31:0]          a_dir_ff  [Axes];
   logic signed [31:0]          a_min_ff  [Axes];
   logic signed [31:0]          a_max_ff  [Axes];

   rbs_pkg::side_type           a_side;
   logic signed [32:0]          num_lo [Axes];
   logic signed [32:0]          num_hi [Axes];
   logic signed [31:0]          quo_lo [Axes];
   logic signed [31:0]          quo_hi [Axes];

   rbs_pkg::side_type           side_ff [0:Lat-1];

   // sort stage
   rbs_pkg::side_type           s_side_ff;
   logic signed [31:0]          s_lo_ff [Axes];
   logic signed [31:0]          s_hi_ff [Axes];

   // fold stage
   rbs_pkg::side_type           f_side_ff;
   logic signed [31:0]          f_near_ff;
   logic signed [31:0]          f_far_ff;
   logic signed [31:0]          near_in;
   logic signed [31:0]          far_in;

   logic                        rsp_valid_ff;
   logic                        rsp_hit_ff;
   logic signed [31:0]          rsp_near_ff;
   logic signed [31:0]          rsp_far_ff;

   assign advance      = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = advance;
   assign csr_ch.ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         epsilon_ff <= rbs_pkg::EPSILON_RST;
         t_start_ff <= rbs_pkg::T_START_RST;
         t_end_ff   <= rbs_pkg::T_END_RST;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            rbs_pkg::CSR_EPSILON: epsilon_ff <= csr_ch.data[rbs_pkg::EPS_W-1:0];
            rbs_pkg::CSR_T_START: t_start_ff <= csr_ch.data;
            rbs_pkg::CSR_T_END:   t_end_ff   <= csr_ch.data;
            default: ;
         endcase
      end
   end

   // input capture
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_org_ff[0] <= req_ch.origin_x;
         a_org_ff[1] <= req_ch.origin_y;
         a_org_ff[2] <= req_ch.origin_z;
         a_dir_ff[0] <= req_ch.dir_x;
         a_dir_ff[1] <= req_ch.dir_y;
         a_dir_ff[2] <= req_ch.dir_z;
         a_min_ff[0] <= req_ch.box_min_x;
         a_min_ff[1] <= req_ch.box_min_y;
         a_min_ff[2] <= req_ch.box_min_z;
         a_max_ff[0] <= req_ch.box_max_x;
         a_max_ff[1] <= req_ch.box_max_y;
         a_max_ff[2] <= req_ch.box_max_z;
      end
   end

   // parallel axis checks and slab numerators
   always_comb begin
      logic [31:0] mag;
      a_side.valid     = a_valid_ff;
      a_side.slab_miss = 1'b0;
      a_side.parallel  = '0;
      for (int i = 0; i < Axes; i++) begin
         mag = a_dir_ff[i][31] ? 32'(-a_dir_ff[i]) : 32'(a_dir_ff[i]);
         a_side.parallel[i] = mag <= {1'b0, epsilon_ff};
         if (a_side.parallel[i] &&
             (a_org_ff[i] < a_min_ff[i] || a_org_ff[i] > a_max_ff[i])) begin
            a_side.slab_miss = 1'b1;
         end
         num_lo[i] = 33'(a_min_ff[i]) - 33'(a_org_ff[i]);
         num_hi[i] = 33'(a_max_ff[i]) - 33'(a_org_ff[i]);
      end
   end

   // two dividers per axis
   for (genvar i = 0; i < Axes; i++) begin : g_axis
      rbs_qdiv #(.FRAC_BITS(FRAC_BITS)) u_div_lo (
         .clock  (clock),
         .enable (advance),
         .num    (num_lo[i]),
         .den    (a_dir_ff[i]),
         .quot   (quo_lo[i])
      );
      rbs_qdiv #(.FRAC_BITS(FRAC_BITS)) u_div_hi (
         .clock  (clock),
         .enable (advance),
         .num    (num_hi[i]),
         .den    (a_dir_ff[i]),
         .quot   (quo_hi[i])
      );
   end

   // flags delayed to match the dividers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < Lat; k++) begin
            side_ff[k] <= '0;
         end
      end else if (advance) begin
         side_ff[0] <= a_side;
         for (int k = 1; k < Lat; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // sort each slab pair
   always_ff @(posedge clock) begin
      if (reset) begin
         s_side_ff <= '0;
      end else if (advance) begin
         s_side_ff <= side_ff[Lat-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < Axes; i++) begin
            if (quo_lo[i] > quo_hi[i]) begin
               s_lo_ff[i] <= quo_hi[i];
               s_hi_ff[i] <= quo_lo[i];
            end else begin
               s_lo_ff[i] <= quo_lo[i];
               s_hi_ff[i] <= quo_hi[i];
            end
         end
      end
   end

   // fold non-parallel axes into the interval
   always_comb begin
      near_in = t_start_ff;
      far_in  = t_end_ff;
      for (int i = 0; i < Axes; i++) begin
         if (!s_side_ff.parallel[i]) begin
            if (s_lo_ff[i] > near_in) near_in = s_lo_ff[i];
            if (s_hi_ff[i] < far_in)  far_in  = s_hi_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_side_ff <= '0;
      end else if (advance) begin
         f_side_ff <= s_side_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         f_near_ff <= near_in;
         f_far_ff  <= far_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= f_side_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         if (f_side_ff.slab_miss) begin
            rsp_hit_ff  <= 1'b0;
            rsp_near_ff <= '0;
            rsp_far_ff  <= '0;
         end else begin
            rsp_hit_ff  <= !(f_near_ff > f_far_ff) && (f_far_ff > $signed({1'b0, epsilon_ff}));
            rsp_near_ff <= f_near_ff;
            rsp_far_ff  <= f_far_ff;
         end
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.hit        = rsp_hit_ff;
   assign rsp_ch.t_near_out = rsp_near_ff;
   assign rsp_ch.t_far_out  = rsp_far_ff;

endmodule

// File: rtl/core/rbs_qdiv.sv
// pipelined restoring divider: (num << FRAC_BITS) / den, truncated, saturated
module rbs_qdiv #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               enable,
   input  logic signed [32:0] num,
   input  logic signed [31:0] den,
   output logic signed [31:0] quot
);

   localparam int NumW  = 33 + FRAC_BITS;
   localparam int Steps = rbs_pkg::QUOT_W;

   logic [32:0]     num_mag;
   logic [31:0]     den_mag;
   logic [NumW-1:0] rem_start;
   logic            ovf_start;

   logic [NumW-1:0] rem_ff [0:Steps];
   logic [31:0]     quo_ff [0:Steps];
   logic [31:0]     den_ff [0:Steps];
   logic            neg_ff [0:Steps];
   logic            ovf_ff [0:Steps];

   // operand magnitudes and early overflow (quotient needs more than 32 bits)
   always_comb begin
      num_mag   = num[32] ? 33'(-num) : 33'(num);
      den_mag   = den[31] ? 32'(-den) : 32'(den);
      rem_start = {num_mag, {FRAC_BITS{1'b0}}};
      ovf_start = (rem_start >> 32) >= NumW'(den_mag);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff[0] <= rem_start;
         quo_ff[0] <= '0;
         den_ff[0] <= den_mag;
         neg_ff[0] <= num[32] ^ den[31];
         ovf_ff[0] <= ovf_start;
      end
   end

   // one quotient bit per stage, most significant first
   for (genvar k = 0; k < Steps; k++) begin : g_step
      localparam int Bit = Steps - 1 - k;
      logic fit;

      assign fit = (rem_ff[k] >> Bit) >= NumW'(den_ff[k]);

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k+1] <= fit ? rem_ff[k] - (NumW'(den_ff[k]) << Bit) : rem_ff[k];
            quo_ff[k+1] <= {quo_ff[k][30:0], fit};
            den_ff[k+1] <= den_ff[k];
            neg_ff[k+1] <= neg_ff[k];
            ovf_ff[k+1] <= ovf_ff[k];
         end
      end
   end

   // sign and saturation
   always_comb begin
      if (ovf_ff[Steps] || quo_ff[Steps][31]) begin
         quot = neg_ff[Steps] ? rbs_pkg::Q_MIN : rbs_pkg::Q_MAX;
      end else if (neg_ff[Steps]) begin
         quot = 32'(-quo_ff[Steps]);
      end else begin
         quot = quo_ff[Steps];
      end
   end

endmodule

// File: rtl/core/rbs_checker.sv
// port level checks for the slab test
module rbs_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_hit,
   input logic signed [31:0] rsp_near,
   input logic signed [31:0] rsp_far
);

   // a waiting result item is held
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp item dropped while stalled");

   // a stalled output freezes the input side
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("req taken while output stalled");

   // a hit always has a non-empty interval
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> rsp_near <= rsp_far)
      else $error("hit with near beyond far");

   // nothing leaves right after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind ray_box_slab_test rbs_checker u_rbs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_hit   (rsp_ch.hit),
   .rsp_near  (rsp_ch.t_near_out),
   .rsp_far   (rsp_ch.t_far_out)
);

// File: tb/ray_box_slab_test_tb.sv
module ray_box_slab_test_tb;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [31:0] org [3];
      logic signed [31:0] dir [3];
      logic signed [31:0] lo [3];
      logic signed [31:0] hi [3];
   } ray_box_type;

   typedef struct {
      logic               hit;
      logic signed [31:0] t_near;
      logic signed [31:0] t_far;
   } slab_result_type;

   localparam int FRAC = 16;
   localparam int LATENCY = 37;
   localparam int LONG_HOLD = 300;
   localparam longint CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rbs_req_if req_ch ();
   rbs_rsp_if rsp_ch ();
   rbs_csr_if csr_ch ();

   ray_box_slab_test #(.FRAC_BITS(FRAC)) i_dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch), .csr_ch(csr_ch)
   );

   // predictor copy of the registers
   logic [30:0]        eps_reg = rbs_pkg::EPSILON_RST;
   logic signed [31:0] t_start_reg = rbs_pkg::T_START_RST;
   logic signed [31:0] t_end_reg = rbs_pkg::T_END_RST;

   ray_box_type     ray_queue [$];
   slab_result_type expected_results [$];
   int  errors = 0;
   int  hits_seen = 0;
   int  results_seen = 0;
   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   int  hold_cycles;
   logic hold_req = 1'b0;
   logic hold_done;
   longint cycle_count = 0;

   // saturating fixed point quotient, truncated toward zero
   function automatic longint slab_quotient(longint num, longint den);
      logic neg;
      longint unsigned n, d, q;
      neg = (num < 0) != (den < 0);
      n = num < 0 ? -num : num;
      d = den < 0 ? -den : den;
      q = (n << FRAC) / d;
      if (neg) return (q >= 64'h8000_0000) ? -64'sh8000_0000 : -longint'(q);
      return (q > 64'h7FFF_FFFF) ? 64'sh7FFF_FFFF : longint'(q);
   endfunction

   function automatic slab_result_type predict_slab(ray_box_type r);
      slab_result_type res;
      longint eps, near_t, far_t, o, dv, mag, t1, t2, tmp;
      logic slab_miss;
      eps = eps_reg;
      near_t = t_start_reg;
      far_t = t_end_reg;
      slab_miss = 1'b0;
      for (int a = 0; a < 3; a++) begin
         o = r.org[a];
         dv = r.dir[a];
         mag = dv < 0 ? -dv : dv;
         if (mag <= eps) begin
            if (o < longint'(r.lo[a]) || o > longint'(r.hi[a])) slab_miss = 1'b1;
         end else begin
            t1 = slab_quotient(longint'(r.lo[a]) - o, dv);
            t2 = slab_quotient(longint'(r.hi[a]) - o, dv);
            if (t1 > t2) begin
               tmp = t1; t1 = t2; t2 = tmp;
            end
            if (t1 > near_t) near_t = t1;
            if (t2 < far_t) far_t = t2;
         end
      end
      if (slab_miss) begin
         res.hit = 1'b0; res.t_near = '0; res.t_far = '0;
      end else begin
         res.hit = !(near_t > far_t || far_t <= eps);
         res.t_near = near_t[31:0];
         res.t_far = far_t[31:0];
      end
      return res;
   endfunction

   // clock
   initial begin
      forever #5 clock = ~clock;
   end

   // timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         {req_ch.origin_x, req_ch.origin_y, req_ch.origin_z} <= '0;
         {req_ch.dir_x, req_ch.dir_y, req_ch.dir_z} <= '0;
         {req_ch.box_min_x, req_ch.box_min_y, req_ch.box_min_z} <= '0;
         {req_ch.box_max_x, req_ch.box_max_y, req_ch.box_max_z} <= '0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (req_ch.valid) begin
            expected_results.insert(expected_results.size(),
                                    predict_slab(ray_queue.pop_front()));
         end
         if (ray_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_ch.valid <= 1'b1;
            req_ch.origin_x <= ray_queue[0].org[0];
            req_ch.origin_y <= ray_queue[0].org[1];
            req_ch.origin_z <= ray_queue[0].org[2];
            req_ch.dir_x <= ray_queue[0].dir[0];
            req_ch.dir_y <= ray_queue[0].dir[1];
            req_ch.dir_z <= ray_queue[0].dir[2];
            req_ch.box_min_x <= ray_queue[0].lo[0];
            req_ch.box_min_y <= ray_queue[0].lo[1];
            req_ch.box_min_z <= ray_queue[0].lo[2];
            req_ch.box_max_x <= ray_queue[0].hi[0];
            req_ch.box_max_y <= ray_queue[0].hi[1];
            req_ch.box_max_z <= ray_queue[0].hi[2];
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // receiver stall, including one long hold-off stretch counted here
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         hold_cycles <= 0;
         hold_done <= 1'b0;
      end else if (hold_req && !hold_done) begin
         rsp_ch.ready <= 1'b0;
         hold_cycles <= hold_cycles + 1;
         if (hold_cycles == LONG_HOLD - 1) hold_done <= 1'b1;
      end else begin
         rsp_ch.ready <= $urandom_range(99) >= recv_idle_pct;
      end
   end

   // monitor
   always @(posedge clock) begin
      slab_result_type exp_res;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         results_seen++;
         if (rsp_ch.hit) hits_seen++;
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result hit=%0b near=%0d far=%0d", $realtime,
                     rsp_ch.hit, rsp_ch.t_near_out, rsp_ch.t_far_out);
            errors++;
         end else begin
            exp_res = expected_results.pop_front();
            if (rsp_ch.hit !== exp_res.hit) begin
               $display("%0t: hit expected %0b actual %0b", $realtime, exp_res.hit, rsp_ch.hit);
               errors++;
            end
            if (rsp_ch.t_near_out !== exp_res.t_near) begin
               $display("%0t: t_near expected %0d actual %0d", $realtime,
                        exp_res.t_near, rsp_ch.t_near_out);
               errors++;
            end
            if (rsp_ch.t_far_out !== exp_res.t_far) begin
               $display("%0t: t_far expected %0d actual %0d", $realtime,
                        exp_res.t_far, rsp_ch.t_far_out);
               errors++;
            end
         end
      end
   end

   function automatic logic signed [31:0] rand_word();
      case ($urandom_range(7))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2: return $signed($urandom_range(2 * 65536)) - 65536;
         3, 4: return $signed($urandom_range(200 * 65536)) - 100 * 65536;
         default: return $urandom;
      endcase
   endfunction

   // random ray against a box that usually holds a chosen point
   function automatic ray_box_type rand_ray();
      ray_box_type r;
      logic signed [31:0] c, s;
      for (int a = 0; a < 3; a++) begin
         if ($urandom_range(9) == 0) begin
            r.org[a] = rand_word(); r.dir[a] = rand_word();
            r.lo[a] = rand_word(); r.hi[a] = rand_word();
         end else begin
            c = $signed($urandom_range(100 * 65536)) - 50 * 65536;
            s = $urandom_range(20 * 65536);
            r.lo[a] = c - s;
            r.hi[a] = c + s;
            r.org[a] = $signed($urandom_range(200 * 65536)) - 100 * 65536;
            case ($urandom_range(5))
               0: r.dir[a] = $signed($urandom_range(200)) - 100;
               1: r.dir[a] = 0;
               default: r.dir[a] = $signed($urandom_range(4 * 65536)) - 2 * 65536;
            endcase
         end
      end
      return r;
   endfunction

   function automatic ray_box_type make_ray(logic signed [31:0] o, logic signed [31:0] d,
                                            logic signed [31:0] l, logic signed [31:0] h);
      ray_box_type r;
      for (int a = 0; a < 3; a++) begin
         r.org[a] = o; r.dir[a] = d; r.lo[a] = l; r.hi[a] = h;
      end
      return r;
   endfunction

   function automatic void add_ray(ray_box_type r);
      ray_queue.insert(ray_queue.size(), r);
   endfunction

   task automatic write_register(rbs_pkg::csr_index_type idx, logic [31:0] value);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      case (idx)
         rbs_pkg::CSR_EPSILON: eps_reg = value[30:0];
         rbs_pkg::CSR_T_START: t_start_reg = value;
         default:              t_end_reg = value;
      endcase
   endtask

   task automatic drain_pipeline();
      while (ray_queue.size() != 0 || req_ch.valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   task automatic random_batch(int count);
      repeat (count) add_ray(rand_ray());
   endtask

   // stimulus
   initial begin
      ray_box_type r;
      csr_ch.valid = 1'b0;
      csr_ch.index = rbs_pkg::CSR_EPSILON;
      csr_ch.data = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // phase one: sender idles often, receiver idles more
      send_idle_pct = 33; recv_idle_pct = 73;

      // directed: field extremes, parallel axes inside and outside, inverted box
      add_ray(make_ray(0, 65536, -65536, 65536));
      add_ray(make_ray(0, 0, -65536, 65536));
      add_ray(make_ray(2 * 65536, 0, -65536, 65536));
      add_ray(make_ray(0, 66, 65536, -65536));
      add_ray(make_ray(0, 67, -65536, 65536));
      add_ray(make_ray(0, 65536, 65536, -65536));
      add_ray(make_ray(32'sh8000_0000, 1 << 10, 32'sh8000_0000, 32'sh7FFF_FFFF));
      add_ray(make_ray(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF));
      add_ray(make_ray(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000));
      add_ray(make_ray(-1, -1, -1, -1));
      add_ray(make_ray(10 * 65536, 65536, -65536, 65536));
      add_ray(make_ray(-10 * 65536, -65536, -65536, 65536));
      add_ray(make_ray(0, -65536, 5 * 65536, 6 * 65536));
      add_ray(make_ray(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA));
      add_ray(make_ray(32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555));
      r = make_ray(0, 65536, -65536, 65536);
      r.dir[1] = 0; r.org[1] = 3 * 65536;
      add_ray(r);
      drain_pipeline();

      write_register(rbs_pkg::CSR_EPSILON, 32'h7FFF_FFFF);
      random_batch(100);
      drain_pipeline();
      write_register(rbs_pkg::CSR_EPSILON, 0);
      write_register(rbs_pkg::CSR_T_START, 32'h8000_0000);
      write_register(rbs_pkg::CSR_T_END, 32'h8000_0000);
      random_batch(150);
      drain_pipeline();

      // phase two: roles swapped, with a long receiver hold-off
      send_idle_pct = 73; recv_idle_pct = 33;
      write_register(rbs_pkg::CSR_EPSILON, 66);
      write_register(rbs_pkg::CSR_T_START, 32'h7FFF_FFFF);
      write_register(rbs_pkg::CSR_T_END, 32'h7FFF_FFFF);
      random_batch(150);
      drain_pipeline();
      send_idle_pct = 0;
      write_register(rbs_pkg::CSR_T_START, 32'hFFF0_0000);
      write_register(rbs_pkg::CSR_T_END, 32'h0100_0000);
      hold_req = 1'b1;
      random_batch(250);
      drain_pipeline();

      // phase three: full throughput, interval bounds back at their defaults
      send_idle_pct = 0; recv_idle_pct = 0;
      write_register(rbs_pkg::CSR_EPSILON, 32'h0000_0100);
      write_register(rbs_pkg::CSR_T_START, 0);
      write_register(rbs_pkg::CSR_T_END, 32'h7FFF_FFFF);
      random_batch(550);
      drain_pipeline();

      $display("covered %0d results, %0d hits, over six register settings",
               results_seen, hits_seen);
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
